// ===== sv/blpg_pkg.sv =====
// ----------------------------------------------------------------------------
// blpg_pkg: shared types and constants for the line pixel generator
// Coordinate widths, request/response payloads, the classified command
// passed from the front end to the back end, and register indexes.
// ----------------------------------------------------------------------------
package blpg_pkg;

  // Coordinate and size widths
  localparam int COORD_BITS = 12;
  localparam int ERR_BITS   = COORD_BITS + 1;
  localparam int SIZE_BITS  = COORD_BITS + 1;
  localparam int COLOR_BITS = 32;

  // Configuration port
  localparam int CFG_INDEX_BITS = 2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_WIDTH  = CFG_INDEX_BITS'(0);
  localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_HEIGHT = CFG_INDEX_BITS'(1);
  localparam logic [SIZE_BITS-1:0] IMAGE_WIDTH_RESET  = SIZE_BITS'(640);
  localparam logic [SIZE_BITS-1:0] IMAGE_HEIGHT_RESET = SIZE_BITS'(480);

  // Request kinds
  localparam logic KIND_START = 1'b0;
  localparam logic KIND_STEP  = 1'b1;

  // Command queue between front and back
  localparam int FIFO_DEPTH      = 2;
  localparam int FIFO_PTR_BITS   = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int FIFO_COUNT_BITS = $clog2(FIFO_DEPTH + 1);

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [SIZE_BITS-1:0]  size_t;
  typedef logic [ERR_BITS-1:0]   err_t;
  typedef logic [COLOR_BITS-1:0] color_t;

  typedef enum logic [1:0] {
    OP_REJECT,
    OP_START,
    OP_STEP
  } cmd_op_t;

  typedef struct packed {
    logic   kind;
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
    color_t line_color;
  } req_t;

  typedef struct packed {
    logic   pixel_valid;
    coord_t pixel_x;
    coord_t pixel_y;
    color_t pixel_color;
    logic   last_pixel;
  } rsp_t;

  // Classified request: a start carries the line setup, ready to run
  typedef struct packed {
    cmd_op_t op;
    coord_t  x;
    coord_t  y;
    coord_t  major;
    coord_t  minor;
    logic    x_major;
    logic    x_neg;
    logic    y_neg;
    color_t  color;
  } cmd_t;

endpackage

// ===== sv/bresenham_line_pixel_generator.sv =====
// ----------------------------------------------------------------------------
// bresenham_line_pixel_generator: Bresenham line rasterizer
// Start requests load a line, step requests return its pixels one by one.
// ----------------------------------------------------------------------------
// Every request returns exactly one response. A start request (kind 0) is
// checked against image_width/image_height: if any endpoint lies outside, the
// response has pixel_valid 0 and last_pixel 1; otherwise it carries the first
// pixel. Each step request (kind 1) returns the next pixel, last_pixel marking
// the final one; a step with no line in progress returns all zeros. The block
// takes one request per clock and returns one response per clock when the
// response side keeps up; an accepted request passes through the command
// queue and then the output register before its response appears (setup is
// combinational into the two-entry command queue, and the stepping engine's
// add, compare and update loads the output register). While responses stall,
// the queue and the output register hold three requests before the input
// stalls. Size registers are sampled when a line starts.
module bresenham_line_pixel_generator (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [blpg_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  blpg_pkg::size_t                     cfg_data,
  input  logic                                req_valid,
  output logic                                req_ready,
  input  blpg_pkg::req_t                      req,
  output logic                                rsp_valid,
  input  logic                                rsp_ready,
  output blpg_pkg::rsp_t                      rsp
);

  logic           front_valid;
  logic           front_ready;
  blpg_pkg::cmd_t front_cmd;
  logic           back_valid;
  logic           back_ready;
  blpg_pkg::cmd_t back_cmd;

  // Intake and setup
  blpg_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .cmd_valid (front_valid),
    .cmd_ready (front_ready),
    .cmd       (front_cmd)
  );

  // Command queue
  blpg_cmd_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (front_valid),
    .wr_ready (front_ready),
    .wr_data  (front_cmd),
    .rd_valid (back_valid),
    .rd_ready (back_ready),
    .rd_data  (back_cmd)
  );

  // Stepping engine
  blpg_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (back_valid),
    .cmd_ready (back_ready),
    .cmd       (back_cmd),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule

// ===== sv/blpg_front.sv =====
// ----------------------------------------------------------------------------
// blpg_front: request intake and line setup
// Holds the image size registers, checks start endpoints against them and
// computes deltas, octant and axis, then pushes one command per request.
// ----------------------------------------------------------------------------
module blpg_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [blpg_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  blpg_pkg::size_t                     cfg_data,
  input  logic                                req_valid,
  output logic                                req_ready,
  input  blpg_pkg::req_t                      req,
  output logic                                cmd_valid,
  input  logic                                cmd_ready,
  output blpg_pkg::cmd_t                      cmd
);

  blpg_pkg::size_t  image_width;
  blpg_pkg::size_t  image_height;
  blpg_pkg::coord_t dx;
  blpg_pkg::coord_t dy;
  logic             x_neg;
  logic             y_neg;
  logic             x_major;
  logic             outside;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= blpg_pkg::IMAGE_WIDTH_RESET;
      image_height <= blpg_pkg::IMAGE_HEIGHT_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        blpg_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        blpg_pkg::REG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Bounds check and delta setup
  always_comb begin
    outside = (blpg_pkg::size_t'(req.start_x) >= image_width)  ||
              (blpg_pkg::size_t'(req.end_x)   >= image_width)  ||
              (blpg_pkg::size_t'(req.start_y) >= image_height) ||
              (blpg_pkg::size_t'(req.end_y)   >= image_height);
    x_neg   = req.end_x < req.start_x;
    y_neg   = req.end_y < req.start_y;
    dx      = x_neg ? (req.start_x - req.end_x) : (req.end_x - req.start_x);
    dy      = y_neg ? (req.start_y - req.end_y) : (req.end_y - req.start_y);
    x_major = dx >= dy;
  end

  // Command build
  always_comb begin
    cmd.x       = req.start_x;
    cmd.y       = req.start_y;
    cmd.major   = x_major ? dx : dy;
    cmd.minor   = x_major ? dy : dx;
    cmd.x_major = x_major;
    cmd.x_neg   = x_neg;
    cmd.y_neg   = y_neg;
    cmd.color   = req.line_color;
    if (req.kind == blpg_pkg::KIND_STEP) begin
      cmd.op = blpg_pkg::OP_STEP;
    end else if (outside) begin
      cmd.op = blpg_pkg::OP_REJECT;
    end else begin
      cmd.op = blpg_pkg::OP_START;
    end
  end

  assign cmd_valid = req_valid;
  assign req_ready = cmd_ready;

endmodule

// ===== sv/blpg_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// blpg_cmd_fifo: command queue between front and back
// Small register queue; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module blpg_cmd_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_valid,
  output logic           wr_ready,
  input  blpg_pkg::cmd_t wr_data,
  output logic           rd_valid,
  input  logic           rd_ready,
  output blpg_pkg::cmd_t rd_data
);

  blpg_pkg::cmd_t                           entries [blpg_pkg::FIFO_DEPTH];
  logic [blpg_pkg::FIFO_PTR_BITS-1:0]       wr_ptr;
  logic [blpg_pkg::FIFO_PTR_BITS-1:0]       rd_ptr;
  logic [blpg_pkg::FIFO_COUNT_BITS-1:0]     count;
  logic                                     push;
  logic                                     pop;

  localparam logic [blpg_pkg::FIFO_PTR_BITS-1:0] LAST_PTR =
    blpg_pkg::FIFO_PTR_BITS'(blpg_pkg::FIFO_DEPTH - 1);
  localparam logic [blpg_pkg::FIFO_COUNT_BITS-1:0] FULL_COUNT =
    blpg_pkg::FIFO_COUNT_BITS'(blpg_pkg::FIFO_DEPTH);

  assign wr_ready = count != FULL_COUNT;
  assign rd_valid = count != '0;
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_ready && rd_valid;
  assign rd_data  = entries[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_COUNT)
    else $error("command queue count exceeds depth");

  a_pop_drains: assert property (@(posedge clk) disable iff (rst)
    (pop && !push) |=> (count == $past(count) - 1'b1))
    else $error("command queue count did not drop on pop");
`endif

endmodule

// ===== sv/blpg_back.sv =====
// ----------------------------------------------------------------------------
// blpg_back: line stepping engine
// Runs one command per cycle, unless a response is stalled, against the line
// state (current point, error term, remaining count); loads the output register.
// ----------------------------------------------------------------------------
module blpg_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_ready,
  input  blpg_pkg::cmd_t cmd,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output blpg_pkg::rsp_t rsp
);

  // Line state
  logic              active,      active_next;
  blpg_pkg::coord_t  cur_x,       cur_x_next;
  blpg_pkg::coord_t  cur_y,       cur_y_next;
  blpg_pkg::err_t    err_acc,     err_acc_next;
  blpg_pkg::coord_t  major_delta, major_delta_next;
  blpg_pkg::coord_t  minor_delta, minor_delta_next;
  blpg_pkg::coord_t  pixels_left, pixels_left_next;
  logic              x_major_axis, x_major_axis_next;
  logic              x_negative,  x_negative_next;
  logic              y_negative,  y_negative_next;
  blpg_pkg::color_t  held_color,  held_color_next;
  blpg_pkg::rsp_t    rsp_next;

  // Advance inputs and results
  blpg_pkg::coord_t  src_x, src_y, src_major, src_minor;
  blpg_pkg::err_t    src_err;
  logic              src_axis, src_xn, src_yn;
  blpg_pkg::err_t    err_sum;
  logic              minor_step;
  blpg_pkg::err_t    adv_err;
  blpg_pkg::coord_t  adv_x, adv_y;
  blpg_pkg::coord_t  left_dec;
  logic              fire;

  function automatic blpg_pkg::coord_t move_coord(blpg_pkg::coord_t c, logic neg);
    return neg ? (c - 1'b1) : (c + 1'b1);
  endfunction

  assign cmd_ready = !rsp_valid || rsp_ready;
  assign fire      = cmd_valid && cmd_ready;
  assign left_dec  = pixels_left - 1'b1;

  // Operand select: a start runs its first advance from the new endpoint
  always_comb begin
    if (cmd.op == blpg_pkg::OP_START) begin
      src_x     = cmd.x;
      src_y     = cmd.y;
      src_major = cmd.major;
      src_minor = cmd.minor;
      src_err   = blpg_pkg::err_t'(cmd.major >> 1);
      src_axis  = cmd.x_major;
      src_xn    = cmd.x_neg;
      src_yn    = cmd.y_neg;
    end else begin
      src_x     = cur_x;
      src_y     = cur_y;
      src_major = major_delta;
      src_minor = minor_delta;
      src_err   = err_acc;
      src_axis  = x_major_axis;
      src_xn    = x_negative;
      src_yn    = y_negative;
    end
  end

  // One Bresenham step
  always_comb begin
    err_sum    = src_err + blpg_pkg::err_t'(src_minor);
    minor_step = err_sum >= blpg_pkg::err_t'(src_major);
    adv_err    = minor_step ? (err_sum - blpg_pkg::err_t'(src_major)) : err_sum;
    adv_x      = src_x;
    adv_y      = src_y;
    if (src_axis) begin
      adv_x = move_coord(src_x, src_xn);
      if (minor_step) begin
        adv_y = move_coord(src_y, src_yn);
      end
    end else begin
      adv_y = move_coord(src_y, src_yn);
      if (minor_step) begin
        adv_x = move_coord(src_x, src_xn);
      end
    end
  end

  // Command decode: next line state and response
  always_comb begin
    active_next       = active;
    cur_x_next        = cur_x;
    cur_y_next        = cur_y;
    err_acc_next      = err_acc;
    major_delta_next  = major_delta;
    minor_delta_next  = minor_delta;
    pixels_left_next  = pixels_left;
    x_major_axis_next = x_major_axis;
    x_negative_next   = x_negative;
    y_negative_next   = y_negative;
    held_color_next   = held_color;
    rsp_next          = '0;
    unique case (cmd.op)
      blpg_pkg::OP_REJECT: begin
        active_next         = 1'b0;
        pixels_left_next    = '0;
        rsp_next.last_pixel = 1'b1;
      end
      blpg_pkg::OP_START: begin
        cur_x_next           = adv_x;
        cur_y_next           = adv_y;
        err_acc_next         = adv_err;
        major_delta_next     = cmd.major;
        minor_delta_next     = cmd.minor;
        pixels_left_next     = cmd.major;
        x_major_axis_next    = cmd.x_major;
        x_negative_next      = cmd.x_neg;
        y_negative_next      = cmd.y_neg;
        held_color_next      = cmd.color;
        active_next          = cmd.major != '0;
        rsp_next.pixel_valid = 1'b1;
        rsp_next.pixel_x     = cmd.x;
        rsp_next.pixel_y     = cmd.y;
        rsp_next.pixel_color = cmd.color;
        rsp_next.last_pixel  = cmd.major == '0;
      end
      blpg_pkg::OP_STEP: begin
        // a step with no line in flight answers all zeros
        if (active) begin
          cur_x_next           = adv_x;
          cur_y_next           = adv_y;
          err_acc_next         = adv_err;
          pixels_left_next     = left_dec;
          active_next          = left_dec != '0;
          rsp_next.pixel_valid = 1'b1;
          rsp_next.pixel_x     = cur_x;
          rsp_next.pixel_y     = cur_y;
          rsp_next.pixel_color = held_color;
          rsp_next.last_pixel  = left_dec == '0;
        end
      end
      default: ;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      active      <= 1'b0;
      pixels_left <= '0;
      rsp_valid   <= 1'b0;
    end else begin
      if (fire) begin
        active      <= active_next;
        pixels_left <= pixels_left_next;
      end
      if (fire) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Line payload and output register
  always_ff @(posedge clk) begin
    if (fire) begin
      cur_x        <= cur_x_next;
      cur_y        <= cur_y_next;
      err_acc      <= err_acc_next;
      major_delta  <= major_delta_next;
      minor_delta  <= minor_delta_next;
      x_major_axis <= x_major_axis_next;
      x_negative   <= x_negative_next;
      y_negative   <= y_negative_next;
      held_color   <= held_color_next;
      rsp          <= rsp_next;
    end
  end

`ifndef ASSERT_OFF
  a_active_has_pixels: assert property (@(posedge clk) disable iff (rst)
    active |-> (pixels_left != '0))
    else $error("line active with no pixels left");

  a_no_pixel_is_blank: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp.pixel_valid) |->
      (rsp.pixel_x == '0 && rsp.pixel_y == '0 && rsp.pixel_color == '0))
    else $error("response without pixel carries nonzero fields");
`endif

endmodule

// ===== tb/bresenham_line_pixel_generator_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bresenham_line_pixel_generator_tb: self-checking bench for the line engine
// Drives start and step requests against several image sizes, predicts each
// response with a cycle-free line stepper and checks every response in order.
// ----------------------------------------------------------------------------
module bresenham_line_pixel_generator_tb;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_OFF_CYCLES = 60;
  localparam int IDLE_PERCENT = 14;

  // Tracks the line engine state and the responses still owed by the block
  class pixel_scoreboard;
    blpg_pkg::size_t  img_width;
    blpg_pkg::size_t  img_height;
    bit               line_active;
    blpg_pkg::coord_t cur_x;
    blpg_pkg::coord_t cur_y;
    blpg_pkg::err_t   error_term;
    blpg_pkg::coord_t major_len;
    blpg_pkg::coord_t minor_len;
    blpg_pkg::coord_t remaining;
    bit               x_major;
    bit               x_down;
    bit               y_down;
    blpg_pkg::color_t held_color;
    blpg_pkg::rsp_t   expected_pixels[$];
    int               mismatches;

    function new();
      img_width   = blpg_pkg::IMAGE_WIDTH_RESET;
      img_height  = blpg_pkg::IMAGE_HEIGHT_RESET;
      line_active = 1'b0;
      cur_x       = '0;
      cur_y       = '0;
      error_term  = '0;
      major_len   = '0;
      minor_len   = '0;
      remaining   = '0;
      x_major     = 1'b0;
      x_down      = 1'b0;
      y_down      = 1'b0;
      held_color  = '0;
      mismatches  = 0;
    endfunction

    function void set_register(logic [blpg_pkg::CFG_INDEX_BITS-1:0] index,
                               blpg_pkg::size_t value);
      if (index == blpg_pkg::REG_IMAGE_WIDTH) begin
        img_width = value;
      end else if (index == blpg_pkg::REG_IMAGE_HEIGHT) begin
        img_height = value;
      end
    endfunction

    function blpg_pkg::coord_t move_one(blpg_pkg::coord_t c, bit down);
      return down ? c - 1'b1 : c + 1'b1;
    endfunction

    // One Bresenham step: minor axis moves when the error term wraps
    function void step_position();
      error_term = error_term + minor_len;
      if (error_term >= major_len) begin
        error_term = error_term - major_len;
        if (x_major) cur_y = move_one(cur_y, y_down);
        else cur_x = move_one(cur_x, x_down);
      end
      if (x_major) cur_x = move_one(cur_x, x_down);
      else cur_y = move_one(cur_y, y_down);
    endfunction

    function void push_pixel(bit valid, blpg_pkg::coord_t x, blpg_pkg::coord_t y,
                             blpg_pkg::color_t c, bit last);
      blpg_pkg::rsp_t p;
      p.pixel_valid = valid;
      p.pixel_x     = x;
      p.pixel_y     = y;
      p.pixel_color = c;
      p.last_pixel  = last;
      expected_pixels.push_back(p);
    endfunction

    function void note_request(blpg_pkg::req_t r);
      blpg_pkg::coord_t dx;
      blpg_pkg::coord_t dy;
      if (r.kind == blpg_pkg::KIND_START) begin
        if (r.start_x >= img_width || r.end_x >= img_width ||
            r.start_y >= img_height || r.end_y >= img_height) begin
          // endpoint off the image: reject and drop any line in flight
          line_active = 1'b0;
          remaining   = '0;
          push_pixel(1'b0, '0, '0, '0, 1'b1);
        end else begin
          x_down     = r.end_x < r.start_x;
          y_down     = r.end_y < r.start_y;
          dx         = x_down ? r.start_x - r.end_x : r.end_x - r.start_x;
          dy         = y_down ? r.start_y - r.end_y : r.end_y - r.start_y;
          x_major    = dx >= dy;
          major_len  = x_major ? dx : dy;
          minor_len  = x_major ? dy : dx;
          error_term = blpg_pkg::err_t'(major_len >> 1);
          remaining  = major_len;
          held_color = r.line_color;
          cur_x      = r.start_x;
          cur_y      = r.start_y;
          push_pixel(1'b1, cur_x, cur_y, held_color, remaining == '0);
          step_position();
          line_active = remaining != '0;
        end
      end else if (!line_active) begin
        push_pixel(1'b0, '0, '0, '0, 1'b0);
      end else begin
        remaining = remaining - 1'b1;
        push_pixel(1'b1, cur_x, cur_y, held_color, remaining == '0);
        step_position();
        line_active = remaining != '0;
      end
    endfunction

    function void check_pixel(blpg_pkg::rsp_t got);
      blpg_pkg::rsp_t want;
      if (expected_pixels.size() == 0) begin
        if (mismatches < 10)
          $display("%0t: response with no request outstanding: %s%0d x=%0d y=%0d %s%h last=%0d",
                   $time, "valid=", got.pixel_valid, got.pixel_x, got.pixel_y,
                   "color=", got.pixel_color, got.last_pixel);
        mismatches++;
      end else begin
        want = expected_pixels.pop_front();
        if (got.pixel_valid !== want.pixel_valid || got.pixel_x !== want.pixel_x ||
            got.pixel_y !== want.pixel_y || got.pixel_color !== want.pixel_color ||
            got.last_pixel !== want.last_pixel) begin
          if (mismatches < 10) begin
            $display("%0t: pixel mismatch", $time);
            $display("  expected valid=%0d x=%0d y=%0d color=%h last=%0d",
                     want.pixel_valid, want.pixel_x, want.pixel_y, want.pixel_color,
                     want.last_pixel);
            $display("  actual   valid=%0d x=%0d y=%0d color=%h last=%0d",
                     got.pixel_valid, got.pixel_x, got.pixel_y, got.pixel_color,
                     got.last_pixel);
          end
          mismatches++;
        end
      end
    endfunction

    function int pending();
      return expected_pixels.size();
    endfunction

    function int failures();
      return mismatches + expected_pixels.size();
    endfunction
  endclass

  logic                                clk;
  logic                                rst;
  logic                                cfg_valid;
  logic                                cfg_ready;
  logic [blpg_pkg::CFG_INDEX_BITS-1:0] cfg_index;
  blpg_pkg::size_t                     cfg_data;
  logic                                req_valid;
  logic                                req_ready;
  blpg_pkg::req_t                      req;
  logic                                rsp_valid;
  logic                                rsp_ready;
  blpg_pkg::rsp_t                      rsp;

  pixel_scoreboard sb = new();
  int  requests_sent = 0;
  int  cycle_count = 0;
  bit  no_gaps = 1'b0;
  int  hold_off_asks = 0;

  bresenham_line_pixel_generator u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Handshake monitor: register writes, accepted requests, responses
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.set_register(cfg_index, cfg_data);
      if (req_valid && req_ready) sb.note_request(req);
      if (rsp_valid && rsp_ready) sb.check_pixel(rsp);
    end
  end

  // Response side: random stalls, plus a long hold-off when asked
  initial begin
    int hold_left;
    int asks_seen;
    hold_left = 0;
    asks_seen = 0;
    rsp_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (asks_seen != hold_off_asks) begin
        asks_seen = hold_off_asks;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= no_gaps || ($urandom_range(0, 99) >= IDLE_PERCENT);
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance
  task automatic send_request(blpg_pkg::req_t r);
    if (!no_gaps && $urandom_range(0, 99) < IDLE_PERCENT) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(negedge clk);
    end
    req_valid <= 1'b1;
    req       <= r;
    forever begin
      @(posedge clk);
      if (req_ready) break;
    end
    requests_sent++;
    @(negedge clk);
  endtask

  task automatic send_start(blpg_pkg::coord_t sx, blpg_pkg::coord_t sy,
                            blpg_pkg::coord_t ex, blpg_pkg::coord_t ey,
                            blpg_pkg::color_t c);
    blpg_pkg::req_t r;
    r.kind       = blpg_pkg::KIND_START;
    r.start_x    = sx;
    r.start_y    = sy;
    r.end_x      = ex;
    r.end_y      = ey;
    r.line_color = c;
    send_request(r);
  endtask

  // Step request; the unused fields carry random junk
  task automatic send_step();
    blpg_pkg::req_t r;
    r.kind       = blpg_pkg::KIND_STEP;
    r.start_x    = blpg_pkg::coord_t'($urandom);
    r.start_y    = blpg_pkg::coord_t'($urandom);
    r.end_x      = blpg_pkg::coord_t'($urandom);
    r.end_y      = blpg_pkg::coord_t'($urandom);
    r.line_color = $urandom;
    send_request(r);
  endtask

  task automatic draw_line(int sx, int sy, int ex, int ey, blpg_pkg::color_t c,
                           int steps);
    send_start(blpg_pkg::coord_t'(sx), blpg_pkg::coord_t'(sy),
               blpg_pkg::coord_t'(ex), blpg_pkg::coord_t'(ey), c);
    repeat (steps) send_step();
  endtask

  // Stop offering and wait for every outstanding response
  task automatic drain();
    req_valid <= 1'b0;
    while (sb.pending() > 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic set_image_size(blpg_pkg::size_t w, blpg_pkg::size_t h);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= blpg_pkg::REG_IMAGE_WIDTH;
    cfg_data  <= w;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    @(negedge clk);
    cfg_index <= blpg_pkg::REG_IMAGE_HEIGHT;
    cfg_data  <= h;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
    repeat (2) @(negedge clk);
  endtask

  function automatic int pick_near(int c, int span, int limit);
    int lo;
    int hi;
    lo = c - span;
    hi = c + span;
    if (lo < 0) lo = 0;
    if (hi > limit - 1) hi = limit - 1;
    return $urandom_range(hi, lo);
  endfunction

  // Mostly complete lines inside the image, some cut short or overrun,
  // plus stray steps and random starts
  task automatic run_lines(int count);
    int target;
    int roll;
    int lim_w;
    int lim_h;
    int sx;
    int sy;
    int ex;
    int ey;
    int span;
    int major;
    int minor;
    int steps;
    target = requests_sent + count;
    while (requests_sent < target) begin
      roll  = $urandom_range(0, 99);
      lim_w = (sb.img_width > 4096) ? 4096 : int'(sb.img_width);
      lim_h = (sb.img_height > 4096) ? 4096 : int'(sb.img_height);
      if (roll < 1) begin
        drain();
      end else if (roll < 8) begin
        send_step();
      end else if (roll < 18 || lim_w == 0 || lim_h == 0) begin
        send_start(blpg_pkg::coord_t'($urandom), blpg_pkg::coord_t'($urandom),
                   blpg_pkg::coord_t'($urandom), blpg_pkg::coord_t'($urandom),
                   $urandom);
      end else begin
        span  = ($urandom_range(0, 99) < 2) ? 150 : 12;
        sx    = $urandom_range(lim_w - 1, 0);
        sy    = $urandom_range(lim_h - 1, 0);
        ex    = pick_near(sx, span, lim_w);
        ey    = pick_near(sy, span, lim_h);
        major = (sx > ex) ? sx - ex : ex - sx;
        minor = (sy > ey) ? sy - ey : ey - sy;
        if (minor > major) major = minor;
        steps = major;
        roll  = $urandom_range(0, 9);
        if (roll == 0) steps = $urandom_range(major, 0);
        else if (roll == 1) steps = major + $urandom_range(3, 1);
        draw_line(sx, sy, ex, ey, $urandom, steps);
      end
    end
  endtask

  initial begin
    rst       = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = blpg_pkg::REG_IMAGE_WIDTH;
    cfg_data  = '0;
    req_valid = 1'b0;
    req       = '0;
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: reset image size 640x480
    send_step();                                   // no line yet
    draw_line(639, 479, 639, 479, 32'hFFFF_FFFF, 0); // single point at far corner
    send_step();                                   // line already finished
    send_start(12'd640, 12'd0, 12'd0, 12'd0, 32'h1234_5678);  // x off image
    send_start(12'd0, 12'd0, 12'd5, 12'd480, 32'h1234_5678);  // y off image
    draw_line(0, 0, 3, 1, 32'h0, 3);               // shallow, rising x
    send_step();                                   // step past the end
    draw_line(10, 10, 11, 14, 32'hA5A5_5A5A, 2);   // steep, cut short
    draw_line(20, 5, 17, 2, 32'h5A5A_A5A5, 3);     // diagonal, both down
    draw_line(300, 200, 296, 198, 32'hCAFE_0001, 1);
    // size change with a line still in progress
    set_image_size(13'd4096, 13'd4096);
    repeat (3) send_step();
    draw_line(4095, 4095, 4092, 4094, 32'hFFFF_FFFF, 3);

    // Full-size image, back-to-back traffic and a long response stall
    no_gaps       <= 1'b1;
    hold_off_asks <= hold_off_asks + 1;
    run_lines(130);
    drain();
    no_gaps <= 1'b0;

    set_image_size(13'd1, 13'd1);
    run_lines(110);
    set_image_size(13'd0, 13'd480);
    run_lines(60);
    set_image_size(13'd640, 13'd0);
    run_lines(60);
    set_image_size(13'h1FFF, 13'h1FFF);
    run_lines(130);
    set_image_size(13'd4096, 13'd1);
    run_lines(120);
    set_image_size(blpg_pkg::size_t'($urandom_range(64, 1)),
                   blpg_pkg::size_t'($urandom_range(64, 1)));
    run_lines(130);
    set_image_size(13'd640, 13'd480);
    run_lines(180);

    drain();
    repeat (8) @(negedge clk);
    if (sb.failures() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
